>>> rtl/slerb_pkg.sv
// ----------------------------------------------------------------------------
// slerb_pkg
// shared types and constants of the serial line echo ring buffer core
// ----------------------------------------------------------------------------
package slerb_pkg;

   localparam int LEVEL_W = 9;

   typedef logic [7:0] byte_type;

   // event codes carried in the operation field
   typedef enum logic [2:0] {
      OP_LINE_RX     = 3'd0,
      OP_TX_READY    = 3'd1,
      OP_HOST_POP    = 3'd2,
      OP_HOST_PUSH   = 3'd3,
      OP_HOST_INJECT = 3'd4,
      OP_BRK_CLR     = 3'd5,
      OP_BRK_SET     = 3'd6
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BS_SPACE,
      ST_BS_BACK,
      ST_EOL_LF,
      ST_SCAN,
      ST_RESP
   } state_type;

   localparam byte_type CHR_ETX   = 8'h03;
   localparam byte_type CHR_BS    = 8'h08;
   localparam byte_type CHR_SPACE = 8'h20;
   localparam byte_type CHR_LF    = 8'h0a;
   localparam byte_type CHR_CR    = 8'h0d;

   typedef struct packed {
      logic [2:0] operation;
      byte_type   data_in;
   } req_type;

   typedef struct packed {
      byte_type             data_out;
      logic                 data_valid;
      logic                 status;
      logic [LEVEL_W-1:0]   rx_level;
      logic [LEVEL_W-1:0]   tx_level;
      logic                 line_ready;
      logic                 break_seen;
   } rsp_type;

   function automatic logic is_eol(input byte_type b);
      return (b == CHR_LF) || (b == CHR_CR);
   endfunction

endpackage

>>> rtl/serial_line_echo_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// serial_line_echo_ring_buffers_core
// console line discipline over a receive ring and a transmit ring with echo
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per event (line byte, transmitter ready, host
//   pop, host push, host inject, break clear, break set) with its data byte
//   rsp channel: exactly one transaction per request, carrying the popped or
//   transmitted byte, a refused/dropped status, both ring levels and flags
//   one request is worked on at a time; req_ready is high only when idle
//   an accepted request passes through the execute and response states, and
//   its response is then loaded into the output register
//   a backspace echo adds states ST_BS_SPACE, ST_BS_BACK, an end-of-line echo
//   ST_EOL_LF, as the transmit memory's single write port takes one byte a cycle
//   popping a newline rescans the receive ring through its read port, one
//   entry a cycle over the bytes left, ending early on a hit
//   reset empties both rings and clears both flags at once, no clearing pass
//   a stalled receiver leaves the response in the output register; the next
//   request is still taken and waits in the response state until it drains
// ----------------------------------------------------------------------------
module serial_line_echo_ring_buffers_core #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  slerb_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output slerb_pkg::rsp_type  rsp_payload
);
   import slerb_pkg::*;

   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int TX_PW = $clog2(TX_DEPTH);
   localparam int RX_FW = $clog2(RX_DEPTH + 1);
   localparam int TX_FW = $clog2(TX_DEPTH + 1);

   // room limits of the line editing rules
   localparam logic [RX_FW-1:0] RX_FULL      = RX_FW'(RX_DEPTH);
   localparam logic [RX_FW-1:0] RX_LIM_PLAIN = RX_FW'(RX_DEPTH - 1);
   localparam logic [TX_FW-1:0] TX_FULL      = TX_FW'(TX_DEPTH);
   localparam logic [TX_FW-1:0] TX_LIM_BS    = TX_FW'(TX_DEPTH - 3);
   localparam logic [TX_FW-1:0] TX_LIM_EOL   = TX_FW'(TX_DEPTH - 2);

   function automatic logic [RX_PW-1:0] rx_next(input logic [RX_PW-1:0] p);
      return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + RX_PW'(1);
   endfunction

   function automatic logic [RX_PW-1:0] rx_prev(input logic [RX_PW-1:0] p);
      return (p == '0) ? RX_PW'(RX_DEPTH - 1) : p - RX_PW'(1);
   endfunction

   function automatic logic [TX_PW-1:0] tx_next(input logic [TX_PW-1:0] p);
      return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + TX_PW'(1);
   endfunction

   // control state
   state_type        state_ff, state_in;
   logic [RX_PW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_FW-1:0] rx_fill_ff, rx_fill_in;
   logic [TX_PW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_FW-1:0] tx_fill_ff, tx_fill_in;
   logic             eol_ff, eol_in, brk_ff, brk_in;
   logic             chk_vld_ff, chk_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [2:0]       op_ff, op_in;
   byte_type         byte_ff, byte_in;
   byte_type         dout_ff, dout_in;
   logic             dvalid_ff, dvalid_in;
   logic             status_ff, status_in;
   logic [RX_PW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [RX_FW-1:0] scan_left_ff, scan_left_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;

   // memory ports
   logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [RX_PW-1:0] rx_wr_addr, rx_rd_addr;
   logic [TX_PW-1:0] tx_wr_addr;
   byte_type         rx_wr_data, tx_wr_data, rx_rd_data, tx_rd_data;

   logic             scan_hit;
   logic             scan_issue;
   logic             rsp_load;

   slerb_ring_mem #(.DEPTH(RX_DEPTH)) u_rx_mem (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (rx_wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   slerb_ring_mem #(.DEPTH(TX_DEPTH)) u_tx_mem (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (tx_wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // rescan: a read issued one cycle is checked the next
   assign scan_hit   = chk_vld_ff && is_eol(rx_rd_data);
   assign scan_issue = (scan_left_ff != '0) && !scan_hit;

   always_comb begin
      state_in     = state_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      rx_fill_in   = rx_fill_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      tx_fill_in   = tx_fill_ff;
      eol_in       = eol_ff;
      brk_in       = brk_ff;
      chk_vld_in   = chk_vld_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      dout_in      = dout_ff;
      dvalid_in    = dvalid_ff;
      status_in    = status_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      rx_wr_en     = 1'b0;
      rx_wr_addr   = rx_head_ff;
      rx_wr_data   = byte_ff;
      rx_rd_en     = 1'b0;
      rx_rd_addr   = rx_tail_ff;
      tx_wr_en     = 1'b0;
      tx_wr_addr   = tx_head_ff;
      tx_wr_data   = byte_ff;
      tx_rd_en     = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // fetch both ring tails ahead of time for transmit and pop
               op_in    = req_payload.operation;
               byte_in  = req_payload.data_in;
               rx_rd_en = 1'b1;
               tx_rd_en = 1'b1;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            dout_in    = '0;
            dvalid_in  = 1'b0;
            status_in  = 1'b0;
            chk_vld_in = 1'b0;
            state_in   = ST_RESP;
            unique case (op_type'(op_ff))
               OP_LINE_RX: begin
                  priority if (byte_ff == CHR_ETX) begin
                     brk_in = 1'b1;
                  end else if (byte_ff == CHR_BS && rx_fill_ff != '0 &&
                               tx_fill_ff < TX_LIM_BS) begin
                     // rub out the newest byte, echo bs space bs
                     rx_head_in = rx_prev(rx_head_ff);
                     rx_fill_in = rx_fill_ff - RX_FW'(1);
                     tx_wr_en   = 1'b1;
                     tx_wr_data = CHR_BS;
                     tx_head_in = tx_next(tx_head_ff);
                     tx_fill_in = tx_fill_ff + TX_FW'(1);
                     state_in   = ST_BS_SPACE;
                  end else if (is_eol(byte_ff) && rx_fill_ff < RX_FULL &&
                               tx_fill_ff < TX_LIM_EOL) begin
                     // store newline, echo cr lf
                     rx_wr_en   = 1'b1;
                     rx_wr_data = CHR_LF;
                     rx_head_in = rx_next(rx_head_ff);
                     rx_fill_in = rx_fill_ff + RX_FW'(1);
                     tx_wr_en   = 1'b1;
                     tx_wr_data = CHR_CR;
                     tx_head_in = tx_next(tx_head_ff);
                     tx_fill_in = tx_fill_ff + TX_FW'(1);
                     eol_in     = 1'b1;
                     state_in   = ST_EOL_LF;
                  end else if (rx_fill_ff < RX_LIM_PLAIN && tx_fill_ff < TX_FULL) begin
                     rx_wr_en   = 1'b1;
                     rx_head_in = rx_next(rx_head_ff);
                     rx_fill_in = rx_fill_ff + RX_FW'(1);
                     tx_wr_en   = 1'b1;
                     tx_head_in = tx_next(tx_head_ff);
                     tx_fill_in = tx_fill_ff + TX_FW'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_TX_READY: begin
                  if (tx_fill_ff != '0) begin
                     dout_in    = tx_rd_data;
                     dvalid_in  = 1'b1;
                     tx_tail_in = tx_next(tx_tail_ff);
                     tx_fill_in = tx_fill_ff - TX_FW'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_HOST_POP: begin
                  if (rx_fill_ff != '0) begin
                     dout_in    = rx_rd_data;
                     dvalid_in  = 1'b1;
                     rx_tail_in = rx_next(rx_tail_ff);
                     rx_fill_in = rx_fill_ff - RX_FW'(1);
                     if (is_eol(rx_rd_data)) begin
                        // look for another line end among the bytes left
                        eol_in       = 1'b0;
                        scan_ptr_in  = rx_next(rx_tail_ff);
                        scan_left_in = rx_fill_ff - RX_FW'(1);
                        state_in     = ST_SCAN;
                     end
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_HOST_PUSH: begin
                  if (tx_fill_ff < TX_FULL) begin
                     tx_wr_en   = 1'b1;
                     tx_head_in = tx_next(tx_head_ff);
                     tx_fill_in = tx_fill_ff + TX_FW'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_HOST_INJECT: begin
                  if (rx_fill_ff < RX_FULL) begin
                     rx_wr_en   = 1'b1;
                     rx_head_in = rx_next(rx_head_ff);
                     rx_fill_in = rx_fill_ff + RX_FW'(1);
                     if (is_eol(byte_ff)) begin
                        eol_in = 1'b1;
                     end
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_BRK_CLR: brk_in = 1'b0;
               OP_BRK_SET: brk_in = 1'b1;
               default: ;
            endcase
         end

         ST_BS_SPACE: begin
            tx_wr_en   = 1'b1;
            tx_wr_data = CHR_SPACE;
            tx_head_in = tx_next(tx_head_ff);
            tx_fill_in = tx_fill_ff + TX_FW'(1);
            state_in   = ST_BS_BACK;
         end

         ST_BS_BACK: begin
            tx_wr_en   = 1'b1;
            tx_wr_data = CHR_BS;
            tx_head_in = tx_next(tx_head_ff);
            tx_fill_in = tx_fill_ff + TX_FW'(1);
            state_in   = ST_RESP;
         end

         ST_EOL_LF: begin
            tx_wr_en   = 1'b1;
            tx_wr_data = CHR_LF;
            tx_head_in = tx_next(tx_head_ff);
            tx_fill_in = tx_fill_ff + TX_FW'(1);
            state_in   = ST_RESP;
         end

         ST_SCAN: begin
            chk_vld_in = scan_issue;
            if (scan_issue) begin
               rx_rd_en     = 1'b1;
               rx_rd_addr   = scan_ptr_ff;
               scan_ptr_in  = rx_next(scan_ptr_ff);
               scan_left_in = scan_left_ff - RX_FW'(1);
            end
            if (scan_hit) begin
               eol_in   = 1'b1;
               state_in = ST_RESP;
            end else if (scan_left_ff == '0 && !chk_vld_ff) begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // wait here while the output register still holds a response
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_payload_in.data_out   = dout_ff;
         rsp_payload_in.data_valid = dvalid_ff;
         rsp_payload_in.status     = status_ff;
         rsp_payload_in.rx_level   = LEVEL_W'(rx_fill_ff);
         rsp_payload_in.tx_level   = LEVEL_W'(tx_fill_ff);
         rsp_payload_in.line_ready = eol_ff;
         rsp_payload_in.break_seen = brk_ff;
      end
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_fill_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_fill_ff   <= '0;
         eol_ff       <= 1'b0;
         brk_ff       <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_fill_ff   <= rx_fill_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_fill_ff   <= tx_fill_in;
         eol_ff       <= eol_in;
         brk_ff       <= brk_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      byte_ff        <= byte_in;
      dout_ff        <= dout_in;
      dvalid_ff      <= dvalid_in;
      status_ff      <= status_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_left_ff   <= scan_left_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

>>> rtl/slerb_ring_mem.sv
// ----------------------------------------------------------------------------
// slerb_ring_mem
// byte memory for one ring: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module slerb_ring_mem #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  slerb_pkg::byte_type          wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output slerb_pkg::byte_type          rd_data
);
   import slerb_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/slerb_core_checker.sv
// ----------------------------------------------------------------------------
// slerb_core_checker
// port-level checks of the serial line echo ring buffer core
// ----------------------------------------------------------------------------
module slerb_core_checker #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input slerb_pkg::req_type  req_payload,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input slerb_pkg::rsp_type  rsp_payload
);
   import slerb_pkg::*;

   // a response held against backpressure stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // a waiting request keeps its valid and its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("request changed while waiting");

   // one transaction in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a delivered byte is never flagged as refused
   a_valid_not_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.data_valid && rsp_payload.status))
      else $error("data valid together with refused status");

   // levels never pass the ring depth; checked only for depths up to 511
   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((RX_DEPTH > 511) || (int'(rsp_payload.rx_level) <= RX_DEPTH)) &&
                    ((TX_DEPTH > 511) || (int'(rsp_payload.tx_level) <= TX_DEPTH)))
      else $error("ring level beyond depth");

endmodule

bind serial_line_echo_ring_buffers_core slerb_core_checker #(
   .RX_DEPTH (RX_DEPTH),
   .TX_DEPTH (TX_DEPTH)
) u_slerb_core_checker (.*);
